// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the transcoder modules.
// Each macro expects signals named clk and rst in the including module.
// Simulation builds get the checks; synthesis builds define SYNTH and get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Holds in every cycle outside reset.
`define U8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define U8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define U8_ASSERT(lbl, prop, msg)

`define U8_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/u8u16_pkg.sv -----
// Types and constants of the UTF-8 to UTF-16 transcoder.
// Used by the decoder, the job queue, the unit emitter and the top level.
package u8u16_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned UNIT_W = 16;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [UNIT_W-1:0] SURR_HI_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h010000;

  localparam logic [2:0] SEQ_LEN1 = 3'd1;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  // One decoded code point or end marker, ready to be written out.
  typedef struct packed {
    logic [UNIT_W-1:0] unit_hi;
    logic [UNIT_W-1:0] unit_lo;
    logic              pair;
    logic              present;
    logic              str_end;
  } u8u16_job_t;

endpackage

// ----- rtl/core/u8u16_if.sv -----
// Handshake channels of the transcoder: UTF-8 byte input and UTF-16 unit output.
// Depends on nothing.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       string_last;

  modport source(output valid, output byte_in, output string_last, input ready);
  modport sink(input valid, input byte_in, input string_last, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_present;
  logic        run_last;
  logic        string_end;

  modport source(output valid, output code_unit, output unit_present,
                 output run_last, output string_end, input ready);
  modport sink(input valid, input code_unit, input unit_present,
               input run_last, input string_end, output ready);
endinterface

// ----- rtl/core/u8u16_front.sv -----
// Decoder: gathers UTF-8 byte sequences; one job per code point or per string end.
// Depends on u8u16_pkg, u8u16_in_if and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_front import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  u8u16_in_if.sink   utf8,
  output logic       job_valid,
  output u8u16_job_t job,
  input  logic       job_ready
);

  logic [1:0]      bse;
  logic [2:0]      seq;
  logic [CP_W-1:0] pcp;

  logic [1:0]      bse_a;
  logic [2:0]      seq_a;
  logic [CP_W-1:0] pcp_a;
  logic [CP_W-1:0] shifted;
  logic [CP_W-1:0] v;
  logic            emit_a;
  logic            do_emit;
  logic            step;
  logic [7:0]      b;

  assign b = utf8.byte_in;

  always_comb begin
    bse_a   = bse;
    seq_a   = seq;
    pcp_a   = pcp;
    emit_a  = 1'b0;
    unique case (bse)
      2'd1:    shifted = {15'd0, b[5:0]};
      2'd2:    shifted = {9'd0, b[5:0], 6'd0};
      default: shifted = {3'd0, b[5:0], 12'd0};
    endcase
    priority if (bse != 2'd0) begin
      pcp_a  = pcp | shifted;
      bse_a  = bse - 2'd1;
      emit_a = (bse == 2'd1);
    end else if (!b[7]) begin
      seq_a  = SEQ_LEN1;
      pcp_a  = {13'd0, b};
      emit_a = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      seq_a = SEQ_LEN2;
      bse_a = 2'd1;
      pcp_a = {10'd0, b[4:0], 6'd0};
    end else if (b[7:4] == 4'b1110) begin
      seq_a = SEQ_LEN3;
      bse_a = 2'd2;
      pcp_a = {5'd0, b[3:0], 12'd0};
    end else if (b[7:3] == 5'b11110) begin
      seq_a = SEQ_LEN4;
      bse_a = 2'd3;
      pcp_a = {b[2:0], 18'd0};
    end else begin
      emit_a = 1'b0;
    end
  end

  always_comb begin
    do_emit     = emit_a || (utf8.string_last && bse_a != 2'd0);
    v           = pcp_a - SUPP_BASE;
    job.pair    = do_emit && (seq_a == SEQ_LEN4) && (pcp_a[CP_W-1:16] != '0);
    job.present = do_emit;
    job.str_end = utf8.string_last;
    job.unit_lo = SURR_LO_BASE + {6'd0, v[9:0]};
    if (job.pair) begin
      job.unit_hi = SURR_HI_BASE + {5'd0, v[CP_W-1:10]};
    end else if (do_emit) begin
      job.unit_hi = pcp_a[UNIT_W-1:0];
    end else begin
      job.unit_hi = '0;
    end
  end

  assign utf8.ready = job_ready;
  assign job_valid  = utf8.valid && (do_emit || utf8.string_last);
  assign step       = utf8.valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bse <= '0;
      seq <= '0;
      pcp <= '0;
    end else if (step) begin
      if (do_emit || utf8.string_last) begin
        bse <= '0;
        seq <= '0;
        pcp <= '0;
      end else begin
        bse <= bse_a;
        seq <= seq_a;
        pcp <= pcp_a;
      end
    end
  end

  `U8_ASSERT(a_pending_len, (bse == 2'd0) || ({1'b0, bse} < seq), "Pending count exceeds sequence length.")
  `U8_ASSERT_NEXT(a_flush, step && utf8.string_last, (bse == 2'd0) && (pcp == '0), "State not cleared after string end.")

endmodule

// ----- rtl/core/u8u16_queue.sv -----
// Short job queue between the decoder and the unit emitter.
// Depends on u8u16_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_queue import u8u16_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  u8u16_job_t in_job,
  output logic       out_valid,
  input  logic       out_ready,
  output u8u16_job_t out_job
);

  u8u16_job_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != QCNT_W'(QDEPTH));
  assign out_valid = (count != '0);
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

  `U8_ASSERT(a_count_range, count <= QCNT_W'(QDEPTH), "Queue count out of range.")
  `U8_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "Queue count missed a push.")

endmodule

// ----- rtl/core/u8u16_back.sv -----
// Unit emitter: turns queued jobs into UTF-16 words behind an output register.
// Depends on u8u16_pkg, u8u16_out_if and assert_macros.svh.
`include "assert_macros.svh"

module u8u16_back import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  output logic        job_ready,
  input  u8u16_job_t  job,
  u8u16_out_if.source utf16
);

  logic              out_valid;
  logic [UNIT_W-1:0] unit_r;
  logic              present_r;
  logic              run_last_r;
  logic              end_r;
  logic              sec_pending;
  logic [UNIT_W-1:0] sec_unit;
  logic              sec_end;
  logic              load;
  logic              pop;

  assign load      = !out_valid || utf16.ready;
  assign job_ready = load && !sec_pending;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      sec_pending <= 1'b0;
    end else if (load) begin
      if (sec_pending) begin
        out_valid   <= 1'b1;
        sec_pending <= 1'b0;
      end else begin
        out_valid   <= job_valid;
        sec_pending <= job_valid && job.pair;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (sec_pending) begin
        unit_r     <= sec_unit;
        present_r  <= 1'b1;
        run_last_r <= 1'b1;
        end_r      <= sec_end;
      end else if (job_valid) begin
        unit_r     <= job.unit_hi;
        present_r  <= job.present;
        run_last_r <= !job.pair;
        end_r      <= job.str_end && !job.pair;
        sec_unit   <= job.unit_lo;
        sec_end    <= job.str_end;
      end
    end
  end

  assign utf16.valid        = out_valid;
  assign utf16.code_unit    = unit_r;
  assign utf16.unit_present = present_r;
  assign utf16.run_last     = run_last_r;
  assign utf16.string_end   = end_r;

  `U8_ASSERT(a_first_half, !sec_pending || (out_valid && !run_last_r && !end_r), "Second unit pending without a first unit shown.")
  `U8_ASSERT_NEXT(a_pair_follows, pop && job.pair, sec_pending && out_valid, "Surrogate pair lost its second unit.")

endmodule

// ----- rtl/core/utf8_to_utf16_transcoder.sv -----
// UTF-8 to UTF-16 transcoder, top level.
// Depends on u8u16_pkg, u8u16_if, u8u16_front, u8u16_queue and u8u16_back.
//
// The utf8 channel takes one byte per word, with string_last set on the final
// byte of a string. The utf16 channel gives one UTF-16 code unit per word;
// run_last marks the last word caused by an input byte and string_end the last
// word of the string. A string whose final byte is invalid where it stands ends
// with a bare marker word that has unit_present low and code_unit zero.
// Bytes are accepted one per cycle while utf8.ready is high. A word caused by a
// byte passes the job queue register and then the output register before it is
// valid on utf16. A code point above 0xFFFF gives its surrogate pair as two
// words; the output gives one word per cycle while the receiver takes them.
// When the receiver stalls, the output register holds its word and the job
// queue fills; once it holds two jobs, utf8.ready stays low until a job moves
// on to the output register, and rises in the cycle after that.
// Reset clears the decoder state, the queue and the output valid at the first
// clock edge with rst high.
module utf8_to_utf16_transcoder import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  u8u16_in_if.sink    utf8,
  u8u16_out_if.source utf16
);

  logic       f_valid;
  logic       f_ready;
  u8u16_job_t f_job;
  logic       b_valid;
  logic       b_ready;
  u8u16_job_t b_job;

  u8u16_front u_front (
    .clk       (clk),
    .rst       (rst),
    .utf8      (utf8),
    .job_valid (f_valid),
    .job       (f_job),
    .job_ready (f_ready)
  );

  u8u16_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_job    (f_job),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_job   (b_job)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (b_valid),
    .job_ready (b_ready),
    .job       (b_job),
    .utf16     (utf16)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for utf8_to_utf16_transcoder: a short table of byte strings, then
// random strings in three handshake pacing modes, words checked against table or predictor.
// Depends on u8u16_pkg, u8u16_if and the transcoder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import u8u16_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_BYTES  = 330;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [15:0] code;
    logic        present;
    logic        run_last;
    logic        str_end;
  } utf16_word_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic        fixed;
    int          n;
    logic [15:0] code;
    logic        present;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  u8u16_in_if  utf8();
  u8u16_out_if utf16();

  utf8_to_utf16_transcoder u_dut (
    .clk   (clk),
    .rst   (rst),
    .utf8  (utf8),
    .utf16 (utf16)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [1:0]  pend_cnt = '0;
  logic [2:0]  pend_len = '0;
  logic [20:0] pend_cp  = '0;

  utf16_word_t step_words[$];
  utf16_word_t expected_words[$];
  logic [7:0]  tx_bytes[$];

  int tx_idle_pct = 29;
  int rx_idle_pct = 55;
  int mismatches = 0;
  int stall_cycles = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int words_seen = 0;
  int surrogates_seen = 0;
  int markers_seen = 0;

  byte_row_t directed_rows [25] = '{
    '{8'h00, 1'b0, 1'b1, 1, 16'h0000, 1'b1},
    '{8'h7F, 1'b1, 1'b1, 1, 16'h007F, 1'b1},
    '{8'h80, 1'b1, 1'b1, 1, 16'h0000, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 0, 16'h0000, 1'b0},
    '{8'hC2, 1'b1, 1'b1, 1, 16'h0080, 1'b1},
    '{8'hE2, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h82, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hAC, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h98, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hF7, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h8F, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hFF, 1'b1, 1'b0, 0, 16'h0000, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 0, 16'h0000, 1'b0},
    '{8'h9F, 1'b1, 1'b0, 0, 16'h0000, 1'b0}
  };

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("word %0d %s: got %h, expected %h", idx, name, got, want));
    end
  endtask

  function automatic void push_unit(input logic [15:0] code, input logic present);
    utf16_word_t w;
    w.code     = code;
    w.present  = present;
    w.run_last = 1'b0;
    w.str_end  = 1'b0;
    step_words = {step_words, w};
  endfunction

  function automatic void emit_point();
    logic [20:0] off;
    if (pend_len == SEQ_LEN4 && pend_cp > 21'h00FFFF) begin
      off = pend_cp - SUPP_BASE;
      push_unit(SURR_HI_BASE + 16'(off >> 10), 1'b1);
      push_unit(SURR_LO_BASE + {6'd0, off[9:0]}, 1'b1);
    end else begin
      push_unit(pend_cp[15:0], 1'b1);
    end
    pend_cnt = '0;
    pend_len = '0;
    pend_cp  = '0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic last);
    step_words.delete();
    if (pend_cnt != 0) begin
      pend_cp  = pend_cp | (21'(b[5:0]) << (6 * (int'(pend_cnt) - 1)));
      pend_cnt = pend_cnt - 2'd1;
      if (pend_cnt == 0) begin
        emit_point();
      end
    end else begin
      casez (b)
        8'b0???????: begin
          pend_len = SEQ_LEN1;
          pend_cp  = 21'(b);
          emit_point();
        end
        8'b110?????: begin
          pend_len = SEQ_LEN2;
          pend_cnt = 2'd1;
          pend_cp  = 21'(b[4:0]) << 6;
        end
        8'b1110????: begin
          pend_len = SEQ_LEN3;
          pend_cnt = 2'd2;
          pend_cp  = 21'(b[3:0]) << 12;
        end
        8'b11110???: begin
          pend_len = SEQ_LEN4;
          pend_cnt = 2'd3;
          pend_cp  = 21'(b[2:0]) << 18;
        end
        default: begin
        end
      endcase
    end
    if (last) begin
      if (pend_cnt != 0) begin
        emit_point();
      end
      if (step_words.size() == 0) begin
        push_unit(16'h0000, 1'b0);
      end
      step_words[step_words.size() - 1].str_end = 1'b1;
      pend_cnt = '0;
      pend_len = '0;
      pend_cp  = '0;
    end
    if (step_words.size() > 0) begin
      step_words[step_words.size() - 1].run_last = 1'b1;
    end
  endfunction

  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    if ($urandom_range(15) == 0) begin
      return {2'($urandom), bits};
    end
    return {2'b10, bits};
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    tx_bytes = {tx_bytes, b};
  endfunction

  function automatic void add_char();
    int          nb;
    logic [20:0] cp;
    nb = $urandom_range(1, 4);
    case (nb)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: cp = 21'($urandom_range('h800, 'hFFFF));
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    if ($urandom_range(7) == 0) begin
      cp = 21'($urandom);
    end
    case (nb)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte(cont_byte(cp[5:0]));
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte(cont_byte(cp[11:6]));
        add_byte(cont_byte(cp[5:0]));
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte(cont_byte(cp[17:12]));
        add_byte(cont_byte(cp[11:6]));
        add_byte(cont_byte(cp[5:0]));
      end
    endcase
  endfunction

  function automatic void build_string();
    int nchars;
    int sel;
    tx_bytes.delete();
    nchars = $urandom_range(1, 6);
    repeat (nchars) begin
      sel = $urandom_range(11);
      if (sel == 9) begin
        add_byte($urandom_range(1) ? {2'b10, 6'($urandom)}
                                   : {5'b11111, 3'($urandom)});
      end else if (sel == 10) begin
        add_byte(8'($urandom));
      end else begin
        add_char();
      end
    end
    if (tx_bytes.size() > 1 && $urandom_range(5) == 0) begin
      tx_bytes.delete(tx_bytes.size() - 1);
    end
  endfunction

  task automatic send_byte(input byte_row_t r);
    utf16_word_t w;
    while ($urandom_range(99) < tx_idle_pct) begin
      utf8.valid <= 1'b0;
      @(posedge clk);
    end
    utf8.valid       <= 1'b1;
    utf8.byte_in     <= r.data;
    utf8.string_last <= r.last;
    do @(posedge clk); while (!utf8.ready);
    bytes_sent++;
    if (r.last) begin
      strings_sent++;
    end
    predict_byte(r.data, r.last);
    if (r.fixed) begin
      if (r.n == 1) begin
        w.code     = r.code;
        w.present  = r.present;
        w.run_last = 1'b1;
        w.str_end  = r.last;
        expected_words = {expected_words, w};
      end
    end else begin
      foreach (step_words[i]) begin
        expected_words = {expected_words, step_words[i]};
      end
    end
  endtask

  task automatic send_string();
    byte_row_t r;
    build_string();
    foreach (tx_bytes[i]) begin
      r.data    = tx_bytes[i];
      r.last    = (i == tx_bytes.size() - 1);
      r.fixed   = 1'b0;
      r.n       = 0;
      r.code    = '0;
      r.present = 1'b0;
      send_byte(r);
    end
  endtask

  always @(posedge clk) begin
    utf16.ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    utf16_word_t want;
    if (!rst) begin
      if (utf16.valid && utf16.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with nothing expected (code_unit %h)",
                                    words_seen, utf16.code_unit));
        end else begin
          want = expected_words.pop_front();
          check_field("code_unit", words_seen, utf16.code_unit, want.code);
          check_field("unit_present", words_seen, 16'(utf16.unit_present), 16'(want.present));
          check_field("run_last", words_seen, 16'(utf16.run_last), 16'(want.run_last));
          check_field("string_end", words_seen, 16'(utf16.string_end), 16'(want.str_end));
        end
        if (!utf16.unit_present) begin
          markers_seen++;
        end else if (utf16.code_unit[15:11] == 5'b11011) begin
          surrogates_seen++;
        end
        words_seen++;
      end
      if ((utf8.valid && utf8.ready) || (utf16.valid && utf16.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("ERROR: no word moved on either channel for %0d cycles", STALL_LIMIT);
    $display("** utf8_to_utf16_transcoder: FAILED **");
    $finish;
  end

  initial begin
    int phase_start;
    utf8.valid       <= 1'b0;
    utf8.byte_in     <= 8'h00;
    utf8.string_last <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i]);
    end
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 55 : 0;
      rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 29 : 0;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        send_string();
      end
    end
    utf8.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d bytes in %0d strings and checked %0d words", bytes_sent,
             strings_sent, words_seen);
    $display("(%0d surrogate units, %0d end markers) under three pacing modes, %0d mismatches.",
             surrogates_seen, markers_seen, mismatches);
    if (mismatches == 0) begin
      $display("** utf8_to_utf16_transcoder: PASSED **");
    end else begin
      $display("** utf8_to_utf16_transcoder: FAILED **");
    end
    $finish;
  end

endmodule
